/* hw/rtl/stable_priority_queue_core_macros.svh */
// Assertion macros for the priority queue checker
`ifndef STABLE_PRIORITY_QUEUE_CORE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_CORE_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define SPQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define SPQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* hw/rtl/spq_pkg.sv */
// Shared types and codes of the stable priority queue
package spq_pkg;
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_SERVE  = 2'd1;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_SERVED   = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_REFUSED  = 3'd3;
  localparam logic [2:0] ST_CLEARED  = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] patient_tag;
    logic [15:0] urgency;
  } spq_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] served_tag;
    logic [8:0]  occupancy;
  } spq_out_t;

  typedef struct packed {
    logic [15:0] tag;
    logic [15:0] urgency;
    logic [31:0] stamp;
  } spq_entry_t;

  // urgency first, then earlier stamp
  function automatic logic spq_ahead(input spq_entry_t x, input spq_entry_t y);
    if (x.urgency != y.urgency) return x.urgency > y.urgency;
    return x.stamp < y.stamp;
  endfunction
endpackage

/* hw/rtl/stable_priority_queue_core.sv */
// Top level of the stable priority queue
// Stable max-priority queue over one synchronous entry memory. Every accepted
// command (start high, busy low) yields exactly one result, shown for one cycle
// on out_valid; the receiver cannot stall it. Insert, clear and a serve of an
// empty queue show their result in the cycle after acceptance, and for every
// command the next one is taken in the cycle after the result. A serve scans
// the memory at one read per cycle, then fetches the tail word, moves it into
// the served slot and shows its result; busy holds until then. The single memory
// read port sets the scan rate. Ties on urgency go to the earliest arrival. No
// clearing pass is needed: the entry count bounds every read.
module stable_priority_queue_core
  import spq_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  spq_in_t  in_item,
  output logic     out_valid,
  output spq_out_t out_item
);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_LAST = 5'b00100,
    S_MOVE = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t      state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [31:0] arrival_r, arrival_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;   // next address issued
  logic [AW-1:0] best_idx_r, best_idx_nxt;
  spq_entry_t  best_r, best_nxt;
  logic        have_best_r, have_best_nxt;
  logic [AW-1:0] cmp_idx_r, cmp_idx_nxt; // address of data now on rd_data
  logic        cmp_vld_r, cmp_vld_nxt;
  spq_out_t    res_r, res_nxt;
  logic        res_vld_r, res_vld_nxt;

  // entry memory
  spq_entry_t  mem [CAPACITY];
  spq_entry_t  rd_data_r;
  logic        we;
  logic [AW-1:0] wa, ra;
  spq_entry_t  wd;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_data_r <= mem[ra];
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    arrival_nxt   = arrival_r;
    rd_idx_nxt    = rd_idx_r;
    best_idx_nxt  = best_idx_r;
    best_nxt      = best_r;
    have_best_nxt = have_best_r;
    cmp_idx_nxt   = cmp_idx_r;
    cmp_vld_nxt   = 1'b0;
    res_nxt       = res_r;
    res_vld_nxt   = 1'b0;
    we = 1'b0;
    wa = count_r[AW-1:0];
    wd = '{tag: in_item.patient_tag, urgency: in_item.urgency, stamp: arrival_r};
    ra = rd_idx_r[AW-1:0];

    // fold the word read last cycle into the running best
    if (cmp_vld_r && (!have_best_r || spq_ahead(rd_data_r, best_r))) begin
      best_nxt      = rd_data_r;
      best_idx_nxt  = cmp_idx_r;
      have_best_nxt = 1'b1;
    end

    case (state_r)
      S_IDLE: begin
        if (start && !busy) begin
          res_vld_nxt = 1'b1;
          res_nxt.served_tag = '0;
          if (in_item.kind[1]) begin
            count_nxt   = '0;
            arrival_nxt = '0;
            res_nxt.status = ST_CLEARED;
          end else if (in_item.kind == KIND_INSERT) begin
            if (count_r >= CW'(CAPACITY) || arrival_r == 32'hFFFF_FFFF) begin
              res_nxt.status = ST_REFUSED;
            end else begin
              we          = 1'b1;
              count_nxt   = count_r + 1'b1;
              arrival_nxt = arrival_r + 32'd1;
              res_nxt.status = ST_INSERTED;
            end
          end else if (count_r == '0) begin
            res_nxt.status = ST_EMPTY;
          end else begin
            res_vld_nxt   = 1'b0;
            have_best_nxt = 1'b0;
            ra            = '0;
            cmp_idx_nxt   = '0;
            cmp_vld_nxt   = 1'b1;
            rd_idx_nxt    = CW'(1);
            state_nxt     = (count_r == CW'(1)) ? S_LAST : S_SCAN;
          end
          res_nxt.occupancy = 9'(count_nxt);
        end
      end
      S_SCAN: begin
        cmp_idx_nxt = rd_idx_r[AW-1:0];
        cmp_vld_nxt = 1'b1;
        rd_idx_nxt  = rd_idx_r + 1'b1;
        if (rd_idx_nxt == count_r) state_nxt = S_LAST;
      end
      S_LAST: begin
        // last compare folds this cycle; fetch the tail word
        ra        = AW'(count_r - 1'b1);
        state_nxt = S_MOVE;
      end
      S_MOVE: begin
        // rd_data_r holds the tail; overwrite the served slot with it
        we = 1'b1;
        wa = best_idx_r;
        wd = rd_data_r;
        count_nxt = count_r - 1'b1;
        res_vld_nxt = 1'b1;
        res_nxt.status     = ST_SERVED;
        res_nxt.served_tag = best_r.tag;
        res_nxt.occupancy  = 9'(count_nxt);
        state_nxt = S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      arrival_r   <= '0;
      res_vld_r   <= 1'b0;
      cmp_vld_r   <= 1'b0;
      have_best_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      arrival_r   <= arrival_nxt;
      res_vld_r   <= res_vld_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      have_best_r <= have_best_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    res_r      <= res_nxt;
  end

  // busy also covers the cycle the result is shown
  assign busy      = (state_r != S_IDLE) || res_vld_r;
  assign out_valid = res_vld_r;
  assign out_item  = res_r;
endmodule

/* hw/rtl/spq_checker.sv */
// Port-level checker for the priority queue, with its bind
`include "stable_priority_queue_core_macros.svh"
module spq_checker
  import spq_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input spq_out_t out_item
);
  `SPQ_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `SPQ_ASSERT_IMP(a_valid_busy, clk, rst_n, out_valid, busy)
  `SPQ_ASSERT_IMP(a_tag_zero, clk, rst_n, out_valid && out_item.status != ST_SERVED,
                  out_item.served_tag == 16'd0)
  `SPQ_ASSERT_IMP(a_clear_empty, clk, rst_n, out_valid && out_item.status == ST_CLEARED,
                  out_item.occupancy == 9'd0)
endmodule

bind stable_priority_queue_core spq_checker u_spq_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_item(out_item)
);

/* tb/tb.sv */
// Self-checking testbench for the stable priority queue core
module tb
  import spq_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = 256;
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  spq_in_t  in_item;
  logic     out_valid;
  spq_out_t out_item;

  stable_priority_queue_core #(.CAPACITY(CAP)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  // predictor copy of the queue state
  spq_entry_t held [CAP];
  int unsigned held_count;
  logic [31:0] next_stamp;

  spq_in_t  pending_cmds[$];
  spq_out_t due_results[$];
  int       gap_left;
  bit       failed;
  int       cycle_count;

  // work out the result of one accepted command and update the predictor
  function automatic spq_out_t predict_queue(input spq_in_t c);
    spq_out_t   r;
    int unsigned best;
    spq_entry_t a, b;
    r = '0;
    if (c.kind[1]) begin
      held_count = 0;
      next_stamp = '0;
      r.status   = ST_CLEARED;
    end else if (c.kind == KIND_INSERT) begin
      if (held_count >= CAP || next_stamp == 32'hFFFF_FFFF) begin
        r.status = ST_REFUSED;
      end else begin
        held[held_count] = '{tag: c.patient_tag, urgency: c.urgency, stamp: next_stamp};
        held_count++;
        next_stamp++;
        r.status = ST_INSERTED;
      end
    end else if (held_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      best = 0;
      for (int unsigned i = 1; i < held_count; i++) begin
        a = held[i];
        b = held[best];
        if (a.urgency > b.urgency || (a.urgency == b.urgency && a.stamp < b.stamp))
          best = i;
      end
      r.served_tag = held[best].tag;
      held_count--;
      held[best] = held[held_count];
      r.status = ST_SERVED;
    end
    r.occupancy = held_count[8:0];
    return r;
  endfunction

  function automatic spq_in_t make_cmd(input logic [1:0] k, input logic [15:0] t,
                                       input logic [15:0] u);
    spq_in_t c;
    c.kind = k;
    c.patient_tag = t;
    c.urgency = u;
    return c;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // driver: one transfer per accepted command, random gap before each
  always @(posedge clk) begin
    if (!rst_n) begin
      start    <= 1'b0;
      in_item  <= '0;
      gap_left <= $urandom_range(0, 11);
    end else if (start && !busy) begin
      // transfer taken at this edge
      due_results.push_back(predict_queue(in_item));
      void'(pending_cmds.pop_front());
      if (pending_cmds.size() != 0 && ($urandom_range(0, 3) == 0)) begin
        // back-to-back: keep start high with the next command
        in_item  <= pending_cmds[0];
        gap_left <= 0;
      end else begin
        start    <= 1'b0;
        gap_left <= $urandom_range(0, 11);
      end
    end else if (!start && pending_cmds.size() != 0) begin
      if (gap_left == 0) begin
        start   <= 1'b1;
        in_item <= pending_cmds[0];
      end else begin
        gap_left <= gap_left - 1;
      end
    end
  end

  // monitor: results cannot be held off, so check every strobe
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_item);
        failed <= 1'b1;
      end else begin
        if (out_item.status !== due_results[0].status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                   due_results[0].status, out_item.status);
          failed <= 1'b1;
        end
        if (out_item.served_tag !== due_results[0].served_tag) begin
          $display("%0t: served_tag mismatch, expected %h, actual %h", $time,
                   due_results[0].served_tag, out_item.served_tag);
          failed <= 1'b1;
        end
        if (out_item.occupancy !== due_results[0].occupancy) begin
          $display("%0t: occupancy mismatch, expected %0d, actual %0d", $time,
                   due_results[0].occupancy, out_item.occupancy);
          failed <= 1'b1;
        end
        void'(due_results.pop_front());
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    logic [1:0] k;
    int roll;
    failed = 1'b0;
    cycle_count = 0;
    held_count = 0;
    next_stamp = '0;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;

    // directed: empty serve, field extremes, urgency ties, spare kind
    pending_cmds.push_back(make_cmd(KIND_SERVE, 16'h0000, 16'h0000));
    pending_cmds.push_back(make_cmd(KIND_INSERT, 16'h0000, 16'h0000));
    pending_cmds.push_back(make_cmd(KIND_INSERT, 16'hFFFF, 16'hFFFF));
    pending_cmds.push_back(make_cmd(KIND_INSERT, 16'h1111, 16'h8000));
    pending_cmds.push_back(make_cmd(KIND_INSERT, 16'h2222, 16'h8000));
    pending_cmds.push_back(make_cmd(KIND_INSERT, 16'h3333, 16'h8000));
    pending_cmds.push_back(make_cmd(KIND_SERVE, 16'hFFFF, 16'hFFFF));
    pending_cmds.push_back(make_cmd(KIND_SERVE, 16'h0000, 16'h0000));
    pending_cmds.push_back(make_cmd(KIND_SERVE, 16'h0000, 16'h0000));
    pending_cmds.push_back(make_cmd(KIND_CLEAR, 16'hAAAA, 16'h5555));
    pending_cmds.push_back(make_cmd(KIND_INSERT, 16'h5555, 16'hAAAA));
    pending_cmds.push_back(make_cmd(KIND_SPARE, 16'hFFFF, 16'hFFFF));
    pending_cmds.push_back(make_cmd(KIND_SERVE, 16'h0000, 16'h0000));

    // fill to capacity, then a refused insert, then drain some
    for (int i = 0; i < CAP; i++)
      pending_cmds.push_back(make_cmd(KIND_INSERT, 16'($urandom),
                                      16'($urandom_range(0, 7))));
    pending_cmds.push_back(make_cmd(KIND_INSERT, 16'hBEEF, 16'hFFFF));
    for (int i = 0; i < 40; i++)
      pending_cmds.push_back(make_cmd(KIND_SERVE, 16'($urandom), 16'($urandom)));
    pending_cmds.push_back(make_cmd(KIND_CLEAR, 16'h0, 16'h0));

    // random part: mostly inserts and serves, few clears; narrow urgency for ties
    for (int i = 0; i < 440; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) k = KIND_INSERT;
      else if (roll < 96) k = KIND_SERVE;
      else k = ($urandom_range(0, 1) != 0) ? KIND_CLEAR : KIND_SPARE;
      pending_cmds.push_back(make_cmd(k, 16'($urandom),
        ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 3)) : 16'($urandom)));
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_cmds.size() == 0);
    wait (due_results.size() == 0);
    // allow a margin before the final check
    repeat (CAP + 20) @(posedge clk);
    if (!failed && due_results.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/spq_pkg.sv
hw/rtl/stable_priority_queue_core.sv
hw/rtl/spq_checker.sv
tb/tb.sv
